/* rtl/plbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbp_pkg: shared definitions for the piecewise linear branch predictor
// Field widths, command codes and register reset values.
// ----------------------------------------------------------------------------
package plbp_pkg;

    localparam int PC_W  = 32;
    localparam int THR_W = 11;

    localparam logic [THR_W-1:0] THR_RESET = 11'd61;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_TRAIN   = 1'b1;

endpackage

/* rtl/plbp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbp request / response channels
// Valid/ready channels carrying branch queries and predictor results.
// ----------------------------------------------------------------------------
interface plbp_req_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [plbp_pkg::PC_W-1:0] pc;
    logic                      outcome;

    modport source (output valid, output command, output pc, output outcome, input ready);
    modport sink   (input valid, input command, input pc, input outcome, output ready);
endinterface

interface plbp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;
    logic weights_updated;

    modport source (output valid, output predict_taken, output weights_updated, input ready);
    modport sink   (input valid, input predict_taken, input weights_updated, output ready);
endinterface

/* rtl/piecewise_linear_branch_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_branch_predictor
// Perceptron style predictor with one weight bank per history position.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+--------------------------------------
//  req     | in  | valid / ready   | command, pc, outcome
//  rsp     | out | valid / ready   | predict_taken, weights_updated
//  cfg     | in  | cfg_wr_en       | cfg_wr_data (training threshold)
//
//  a new item is taken only once the last one has left the decide step:
//  bank read, two adder tree stages, decide and write back into the HIST_LEN weight banks
//  after reset the banks are cleared one address per cycle,
//  all 2**(PC_INDEX_BITS+ADDR_HIST_BITS) addresses, with req.ready low
//  a stalled rsp holds the next item in the decide step until the output frees
// ----------------------------------------------------------------------------
module piecewise_linear_branch_predictor #(
    parameter int HIST_LEN       = 18,
    parameter int PC_INDEX_BITS  = 4,
    parameter int ADDR_HIST_BITS = 4,
    parameter int WEIGHT_BITS    = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    plbp_req_if.sink                     req,
    plbp_rsp_if.source                   rsp,
    input  logic                         cfg_wr_en,
    input  logic [plbp_pkg::THR_W-1:0]   cfg_wr_data
);

    localparam int BANK_AW    = PC_INDEX_BITS + ADDR_HIST_BITS;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int TERM_W     = WEIGHT_BITS + 1;
    localparam int GRP_W      = WEIGHT_BITS + 3;
    localparam int NGRP       = (HIST_LEN + 3) / 4;
    localparam int SUM_W      = WEIGHT_BITS + $clog2(HIST_LEN + 1) + 1;
    localparam int CMP_W      = (SUM_W > plbp_pkg::THR_W) ? SUM_W : plbp_pkg::THR_W;

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM1,
        S_SUM2,
        S_DECIDE
    } state_t;

    state_t                              state_reg;
    logic [BANK_AW-1:0]                  clr_reg;
    logic [plbp_pkg::THR_W-1:0]          thr_reg;
    logic [HIST_LEN-1:0]                 hist_reg;
    logic [ADDR_HIST_BITS-1:0]           addr_hist_reg [HIST_LEN];
    logic signed [WEIGHT_BITS-1:0]       bias_reg;
    logic                                rsp_valid_reg;

    logic                                cmd_reg;
    logic                                outcome_reg;
    logic [PC_INDEX_BITS-1:0]            row_reg;
    logic [ADDR_HIST_BITS-1:0]           new_addr_reg;
    logic signed [WEIGHT_BITS-1:0]       rd_data_reg [HIST_LEN];
    logic signed [GRP_W-1:0]             grp_reg [NGRP];
    logic signed [SUM_W-1:0]             y_reg;
    logic                                predict_taken_reg;
    logic                                weights_updated_reg;

    logic                                in_xfer;
    logic                                out_free;
    logic signed [TERM_W-1:0]            term [HIST_LEN];
    logic signed [GRP_W-1:0]             grp_next [NGRP];
    logic signed [SUM_W-1:0]             y_next;
    logic                                pred;
    logic [SUM_W-1:0]                    mag;
    logic                                need_upd;
    logic signed [WEIGHT_BITS-1:0]       bias_next;
    logic signed [WEIGHT_BITS-1:0]       wr_data [HIST_LEN];
    logic                                wr_en;

    function automatic logic signed [WEIGHT_BITS-1:0] sat_step(
        input logic signed [WEIGHT_BITS-1:0] w,
        input logic                          up
    );
        logic signed [WEIGHT_BITS-1:0] r;
        if (up)
        begin
            r = (w == W_MAX) ? w : w + WEIGHT_BITS'(1);
        end
        else
        begin
            r = (w == W_MIN) ? w : w - WEIGHT_BITS'(1);
        end
        return r;
    endfunction

    assign req.ready         = (state_reg == S_IDLE);
    assign in_xfer           = req.valid && req.ready;
    assign out_free          = !rsp_valid_reg || rsp.ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.predict_taken = predict_taken_reg;
    assign rsp.weights_updated = weights_updated_reg;

    // signed terms and first tree level, four terms per group
    always_comb
    begin
        for (int j = 0; j < HIST_LEN; j++)
        begin
            term[j] = hist_reg[j] ? TERM_W'(rd_data_reg[j]) : -TERM_W'(rd_data_reg[j]);
        end
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (g * 4 + k < HIST_LEN)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(term[g * 4 + k]);
                end
            end
        end
    end

    always_comb
    begin
        y_next = SUM_W'(bias_reg);
        for (int g = 0; g < NGRP; g++)
        begin
            y_next = y_next + SUM_W'(grp_reg[g]);
        end
    end

    assign pred     = !y_reg[SUM_W-1];
    assign mag      = y_reg[SUM_W-1] ? SUM_W'(-y_reg) : SUM_W'(y_reg);
    assign need_upd = (cmd_reg == plbp_pkg::CMD_TRAIN) &&
                      ((pred != outcome_reg) || (CMP_W'(mag) <= CMP_W'(thr_reg)));
    assign bias_next = sat_step(bias_reg, outcome_reg);

    assign wr_en = (state_reg == S_CLEAR) || (state_reg == S_DECIDE && out_free && need_upd);

    always_comb
    begin
        for (int j = 0; j < HIST_LEN; j++)
        begin
            // weight moves up when its history bit agrees with the outcome
            wr_data[j] = (state_reg == S_CLEAR) ? '0 :
                         sat_step(rd_data_reg[j], hist_reg[j] == outcome_reg);
        end
    end

    for (genvar j = 0; j < HIST_LEN; j++)
    begin : g_bank
        logic [WEIGHT_BITS-1:0] mem [BANK_DEPTH];
        logic [BANK_AW-1:0]     raddr;
        logic [BANK_AW-1:0]     waddr;

        assign raddr = {req.pc[PC_INDEX_BITS-1:0], addr_hist_reg[j]};
        assign waddr = (state_reg == S_CLEAR) ? clr_reg : {row_reg, addr_hist_reg[j]};

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[waddr] <= wr_data[j];
            end
            if (in_xfer)
            begin
                rd_data_reg[j] <= mem[raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            thr_reg       <= plbp_pkg::THR_RESET;
            hist_reg      <= '0;
            bias_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int j = 0; j < HIST_LEN; j++)
            begin
                addr_hist_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end

            if (state_reg == S_DECIDE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BANK_AW'(1);
                    if (clr_reg == {BANK_AW{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_SUM1;
                    end
                end
                S_SUM1:
                begin
                    state_reg <= S_SUM2;
                end
                S_SUM2:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (need_upd)
                        begin
                            bias_reg <= bias_next;
                        end
                        if (cmd_reg == plbp_pkg::CMD_TRAIN)
                        begin
                            hist_reg <= HIST_LEN'({hist_reg, outcome_reg});
                            for (int j = HIST_LEN - 1; j > 0; j--)
                            begin
                                addr_hist_reg[j] <= addr_hist_reg[j-1];
                            end
                            addr_hist_reg[0] <= new_addr_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg      <= req.command;
            outcome_reg  <= req.outcome;
            row_reg      <= req.pc[PC_INDEX_BITS-1:0];
            new_addr_reg <= req.pc[ADDR_HIST_BITS-1:0];
        end
        if (state_reg == S_SUM1)
        begin
            grp_reg <= grp_next;
        end
        if (state_reg == S_SUM2)
        begin
            y_reg <= y_next;
        end
        if (state_reg == S_DECIDE && out_free)
        begin
            predict_taken_reg   <= pred;
            weights_updated_reg <= need_upd;
        end
    end

endmodule

/* rtl/plbp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbp_checker
// Port level checks for the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module plbp_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_command,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_predict_taken,
    input logic rsp_weights_updated
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pending_reg;
    logic       cmd0_reg;
    logic       cmd1_reg;

    assign in_xfer  = req_valid && req_ready;
    assign out_xfer = rsp_valid && rsp_ready;

    // commands of items still owed a result, oldest first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            cmd0_reg    <= plbp_pkg::CMD_PREDICT;
            cmd1_reg    <= plbp_pkg::CMD_PREDICT;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_xfer) - 2'(out_xfer);
            case ({in_xfer, out_xfer})
                2'b10:
                begin
                    if (pending_reg == 2'd0)
                    begin
                        cmd0_reg <= req_command;
                    end
                    else
                    begin
                        cmd1_reg <= req_command;
                    end
                end
                2'b01:
                begin
                    cmd0_reg <= cmd1_reg;
                end
                2'b11:
                begin
                    if (pending_reg == 2'd1)
                    begin
                        cmd0_reg <= req_command;
                    end
                    else
                    begin
                        cmd0_reg <= cmd1_reg;
                        cmd1_reg <= req_command;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_predict_taken)
                                    && $stable(rsp_weights_updated))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted item");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !req_ready)
        else $error("more than one item in work behind a waiting result");

    a_predict_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_weights_updated |-> cmd0_reg == plbp_pkg::CMD_TRAIN)
        else $error("weights updated on a predict item");

endmodule

bind piecewise_linear_branch_predictor plbp_checker u_plbp_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_command         (req.command),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_predict_taken   (rsp.predict_taken),
    .rsp_weights_updated (rsp.weights_updated)
);
